// File: rtl/homing_cubic_trajectory_core_assert.svh
// ----------------------------------------------------------------------------
// Homing cubic trajectory core assertion macros
// Shared concurrent assertion forms on clock and reset.
// ----------------------------------------------------------------------------
`ifndef HOMING_CUBIC_TRAJECTORY_CORE_ASSERT_SVH
`define HOMING_CUBIC_TRAJECTORY_CORE_ASSERT_SVH

// check a property outside reset
`define HCT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("homing core check failed");

// check a property on every edge, reset included
`define HCT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("homing core check failed");

`endif

// File: rtl/hct_pkg.sv
// ----------------------------------------------------------------------------
// Homing cubic trajectory package
// Shared widths, codes, sequencer states and divider interface types.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam int DUR_W      = 24;
   localparam int DIVD_W     = 42;
   localparam int CNT_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   localparam logic [CNT_W-1:0] DIV_ITERS_FULL = 6'd42;
   localparam logic [CNT_W-1:0] DIV_ITERS_FRAC = 6'd30;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE        = 3'd4;

   localparam logic [24:0] RST_TARGET_HIGH = 25'sd6553600;
   localparam logic [24:0] RST_TARGET_LOW  = -25'sd1310720;
   localparam logic [23:0] RST_SPEED       = 24'd524288;
   localparam logic [7:0]  RST_TICK_PERIOD = 8'd5;
   localparam logic        RST_MODE        = 1'b1;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_T,
      ST_DIV_S,
      ST_MUL_SS,
      ST_MUL_S3,
      ST_K,
      ST_MUL_PK,
      ST_MUL_W,
      ST_Y,
      ST_VNUM,
      ST_DIV_V,
      ST_FINAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DUR_W-1:0]  rem_init;
      logic [DIVD_W-1:0] dividend;
      logic [DUR_W-1:0]  divisor;
      logic [CNT_W-1:0]  iters;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/hct_divider.sv
// ----------------------------------------------------------------------------
// Homing cubic trajectory divider
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
module hct_divider (
   input  logic                clock,
   input  logic                reset,
   input  hct_pkg::div_req_type div_req,
   output hct_pkg::div_rsp_type div_rsp
);

   logic [hct_pkg::DUR_W-1:0]  rem_ff, rem_in;
   logic [hct_pkg::DIVD_W-1:0] dq_ff, dq_in;
   logic [hct_pkg::DUR_W-1:0]  dvs_ff, dvs_in;
   logic [hct_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [hct_pkg::DUR_W:0]    shifted;
   logic [hct_pkg::DUR_W:0]    diff;
   logic                       ge;

   assign shifted = {rem_ff, dq_ff[hct_pkg::DIVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         dq_in   = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = div_req.iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? diff[hct_pkg::DUR_W-1:0] : shifted[hct_pkg::DUR_W-1:0];
            dq_in  = {dq_ff[hct_pkg::DIVD_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = busy_ff && (cnt_ff == '0);
   assign div_rsp.quotient = dq_ff;

endmodule

// File: rtl/homing_cubic_trajectory_core.sv
// ----------------------------------------------------------------------------
// Homing cubic trajectory core
// Rest-to-rest cubic homing reference for one joint, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel  ports                                     direction
//  req      req_valid/req_ready, kind, position, sw   in
//  rsp      rsp_valid/rsp_ready, cmd pos/vel, flags   out
//  csr      csr_write_en, csr_index, csr_wdata        in
//
//  Start, idle and homing ticks on a running segment go from PREP to DONE; a
//  running tick does the fraction divide, multiplies and velocity divide; an
//  opening tick does the duration divide first, ending there if zero-length or
//  homing. All divides share a restoring divider, one quotient bit per cycle.
//  Reset is synchronous; one request is in work at a time.
//  A finished result waits in the output register while a new request enters.
module homing_cubic_trajectory_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic signed [31:0]                req_measured_position,
   input  logic                              req_switch_level,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_cmd_position,
   output logic signed [31:0]                rsp_cmd_velocity,
   output logic                              rsp_homed,
   output logic                              rsp_busy_res,
   input  logic                              csr_write_en,
   input  logic [hct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hct_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   hct_pkg::state_type state_ff, state_in;

   logic [24:0] th_ff, tl_ff;
   logic [23:0] speed_ff;
   logic [7:0]  period_ff;
   logic        mode_ff;

   logic        active_ff, active_in;
   logic        seg_ff, seg_in;
   logic        sas_ff, sas_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        dzero_ff, dzero_in;
   logic [23:0] dur_ff, dur_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [31:0] last_ff, last_in;

   logic        kind_ff, kind_in;
   logic [31:0] meas_ff, meas_in;
   logic        sw_ff, sw_in;

   logic [63:0] prod_ff, prod_in;
   logic [29:0] s_ff, s_in;
   logic [29:0] s2_ff, s2_in;
   logic [31:0] k_ff, k_in;
   logic [33:0] pm_ff, pm_in;
   logic [47:0] y_ff, y_in;

   logic [31:0] res_pos_ff, res_pos_in;
   logic [31:0] res_vel_ff, res_vel_in;
   logic        res_homed_ff, res_homed_in;
   logic        res_busy_ff, res_busy_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pos_ff, rsp_pos_in;
   logic [31:0] rsp_vel_ff, rsp_vel_in;
   logic        rsp_homed_ff, rsp_homed_in;
   logic        rsp_busy_ff, rsp_busy_in;

   hct_pkg::div_req_type div_req;
   hct_pkg::div_rsp_type div_rsp;

   logic [31:0] mul_a, mul_b;
   logic [24:0] target;
   logic [33:0] delta, delta_abs;
   logic [23:0] sp_eff;
   logic [41:0] dur_num;
   logic [23:0] t_sat;
   logic        run_done;
   logic        open_done;
   logic        slot_free;
   logic [63:0] w_val;
   logic [63:0] y_sum;
   logic [57:0] vnum;
   logic [64:0] pm_sum;
   logic [35:0] pos_sum;
   logic [31:0] pos_sat;
   logic [31:0] vel_sat;
   logic [41:0] q;
   logic [24:0] el_next;

   hct_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign q         = div_rsp.quotient;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign target    = sw_ff ? th_ff : tl_ff;
   assign delta     = {{9{target[24]}}, target} - {{2{meas_ff[31]}}, meas_ff};
   assign delta_abs = delta[33] ? (34'd0 - delta) : delta;
   assign sp_eff    = (speed_ff == '0) ? 24'd1 : speed_ff;
   assign dur_num   = {delta_abs[31:0], 10'd0} - {6'd0, delta_abs[31:0], 4'd0}
                    - {7'd0, delta_abs[31:0], 3'd0} + {19'd0, sp_eff[23:1]};
   assign t_sat     = (q[41:24] != '0) ? 24'hFFFFFF : q[23:0];
   assign run_done  = !sw_ff && (!mode_ff || sas_ff);
   assign open_done = !sw_ff && !mode_ff;
   assign w_val     = {prod_ff[61:0], 2'b0} + {prod_ff[62:0], 1'b0};
   assign y_sum     = w_val + 64'd8192;
   assign vnum      = {y_ff, 10'd0} - {6'd0, y_ff, 4'd0} - {7'd0, y_ff, 3'd0}
                    + {19'd0, dur_ff, 15'd0};
   assign pm_sum    = {1'b0, prod_ff} + 65'd536870912;
   assign pos_sum   = {{4{start_ff[31]}}, start_ff}
                    + (neg_ff ? (36'd0 - {2'b0, pm_ff}) : {2'b0, pm_ff});
   assign pos_sat   = (pos_sum[35:31] == 5'b00000 || pos_sum[35:31] == 5'b11111)
                    ? pos_sum[31:0]
                    : (pos_sum[35] ? 32'h8000_0000 : 32'h7FFF_FFFF);
   assign el_next   = {1'b0, elapsed_ff} + {17'd0, period_ff};

   always_comb begin
      if (neg_ff) begin
         vel_sat = (q > 42'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
      end else begin
         vel_sat = (q >= 42'h0_8000_0000) ? 32'h7FFF_FFFF : q[31:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hct_pkg::ST_IDLE: begin
            if (req_valid) state_in = hct_pkg::ST_PREP;
         end
         hct_pkg::ST_PREP: begin
            if (kind_ff == hct_pkg::KIND_START || !active_ff) begin
               state_in = hct_pkg::ST_DONE;
            end else if (!seg_ff) begin
               state_in = hct_pkg::ST_DIV_T;
            end else if (run_done) begin
               state_in = hct_pkg::ST_DONE;
            end else begin
               state_in = hct_pkg::ST_DIV_S;
            end
         end
         hct_pkg::ST_DIV_T: begin
            if (div_rsp.done) begin
               if (dzero_ff || t_sat == '0 || open_done) begin
                  state_in = hct_pkg::ST_DONE;
               end else begin
                  state_in = hct_pkg::ST_DIV_S;
               end
            end
         end
         hct_pkg::ST_DIV_S: begin
            if (div_rsp.done) state_in = hct_pkg::ST_MUL_SS;
         end
         hct_pkg::ST_MUL_SS: state_in = hct_pkg::ST_MUL_S3;
         hct_pkg::ST_MUL_S3: state_in = hct_pkg::ST_K;
         hct_pkg::ST_K:      state_in = hct_pkg::ST_MUL_PK;
         hct_pkg::ST_MUL_PK: state_in = hct_pkg::ST_MUL_W;
         hct_pkg::ST_MUL_W:  state_in = hct_pkg::ST_Y;
         hct_pkg::ST_Y:      state_in = hct_pkg::ST_VNUM;
         hct_pkg::ST_VNUM:   state_in = hct_pkg::ST_DIV_V;
         hct_pkg::ST_DIV_V: begin
            if (div_rsp.done) state_in = hct_pkg::ST_FINAL;
         end
         hct_pkg::ST_FINAL: state_in = hct_pkg::ST_DONE;
         hct_pkg::ST_DONE: begin
            if (slot_free) state_in = hct_pkg::ST_IDLE;
         end
         default: state_in = hct_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: divider launch and multiplier operands
   always_comb begin
      div_req = '0;
      mul_a   = '0;
      mul_b   = '0;
      case (state_ff)
         hct_pkg::ST_PREP: begin
            if (kind_ff == hct_pkg::KIND_TICK && active_ff) begin
               if (!seg_ff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = dur_num;
                  div_req.divisor  = sp_eff;
                  div_req.iters    = hct_pkg::DIV_ITERS_FULL;
               end else if (!run_done) begin
                  div_req.start    = 1'b1;
                  div_req.rem_init = elapsed_ff;
                  div_req.divisor  = dur_ff;
                  div_req.iters    = hct_pkg::DIV_ITERS_FRAC;
               end
            end
         end
         hct_pkg::ST_DIV_T: begin
            if (div_rsp.done && !(dzero_ff || t_sat == '0 || open_done)) begin
               div_req.start   = 1'b1;
               div_req.divisor = t_sat;
               div_req.iters   = hct_pkg::DIV_ITERS_FRAC;
            end
         end
         hct_pkg::ST_MUL_SS: begin
            mul_a = {2'b0, s_ff};
            mul_b = {2'b0, s_ff};
         end
         hct_pkg::ST_MUL_S3: begin
            mul_a = {2'b0, prod_ff[59:30]};
            mul_b = {2'b0, s_ff};
         end
         hct_pkg::ST_MUL_PK: begin
            mul_a = mag_ff;
            mul_b = k_ff;
         end
         hct_pkg::ST_MUL_W: begin
            mul_a = mag_ff;
            mul_b = {2'b0, s_ff - s2_ff};
         end
         hct_pkg::ST_VNUM: begin
            div_req.start    = 1'b1;
            div_req.dividend = vnum[57:16];
            div_req.divisor  = dur_ff;
            div_req.iters    = hct_pkg::DIV_ITERS_FULL;
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   // datapath
   always_comb begin
      active_in    = active_ff;
      seg_in       = seg_ff;
      sas_in       = sas_ff;
      start_in     = start_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      dzero_in     = dzero_ff;
      dur_in       = dur_ff;
      elapsed_in   = elapsed_ff;
      last_in      = last_ff;
      kind_in      = kind_ff;
      meas_in      = meas_ff;
      sw_in        = sw_ff;
      prod_in      = mul_a * mul_b;
      s_in         = s_ff;
      s2_in        = s2_ff;
      k_in         = k_ff;
      pm_in        = pm_ff;
      y_in         = y_ff;
      res_pos_in   = res_pos_ff;
      res_vel_in   = res_vel_ff;
      res_homed_in = res_homed_ff;
      res_busy_in  = res_busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_homed_in = rsp_homed_ff;
      rsp_busy_in  = rsp_busy_ff;
      case (state_ff)
         hct_pkg::ST_IDLE: begin
            kind_in = req_kind;
            meas_in = req_measured_position;
            sw_in   = req_switch_level;
         end
         hct_pkg::ST_PREP: begin
            res_pos_in   = last_ff;
            res_vel_in   = '0;
            res_homed_in = 1'b0;
            res_busy_in  = 1'b1;
            if (kind_ff == hct_pkg::KIND_START) begin
               if (!active_ff) begin
                  active_in = 1'b1;
                  seg_in    = 1'b0;
               end
            end else if (!active_ff) begin
               res_busy_in = 1'b0;
            end else if (!seg_ff) begin
               start_in = meas_ff;
               sas_in   = sw_ff;
               mag_in   = delta_abs[31:0];
               neg_in   = delta[33];
               dzero_in = (delta == '0);
            end else if (run_done) begin
               active_in    = 1'b0;
               seg_in       = 1'b0;
               last_in      = '0;
               res_pos_in   = '0;
               res_homed_in = 1'b1;
               res_busy_in  = 1'b0;
            end
         end
         hct_pkg::ST_DIV_T: begin
            if (div_rsp.done) begin
               if (dzero_ff || t_sat == '0) begin
                  last_in    = meas_ff;
                  res_pos_in = meas_ff;
               end else if (open_done) begin
                  dur_in       = t_sat;
                  elapsed_in   = '0;
                  active_in    = 1'b0;
                  seg_in       = 1'b0;
                  last_in      = '0;
                  res_pos_in   = '0;
                  res_homed_in = 1'b1;
                  res_busy_in  = 1'b0;
               end else begin
                  dur_in     = t_sat;
                  elapsed_in = '0;
                  seg_in     = 1'b1;
               end
            end
         end
         hct_pkg::ST_DIV_S: begin
            if (div_rsp.done) s_in = q[29:0];
         end
         hct_pkg::ST_MUL_S3: begin
            s2_in = prod_ff[59:30];
         end
         hct_pkg::ST_K: begin
            k_in = {2'b0, s2_ff} + {1'b0, s2_ff, 1'b0} - {1'b0, prod_ff[59:30], 1'b0};
         end
         hct_pkg::ST_MUL_W: begin
            pm_in = pm_sum[63:30];
         end
         hct_pkg::ST_Y: begin
            y_in = y_sum[61:14];
         end
         hct_pkg::ST_FINAL: begin
            res_pos_in = pos_sat;
            res_vel_in = vel_sat;
            last_in    = pos_sat;
            if (el_next >= {1'b0, dur_ff}) begin
               elapsed_in = dur_ff;
               seg_in     = 1'b0;
            end else begin
               elapsed_in = el_next[23:0];
            end
         end
         hct_pkg::ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = res_pos_ff;
               rsp_vel_in   = res_vel_ff;
               rsp_homed_in = res_homed_ff;
               rsp_busy_in  = res_busy_ff;
            end
         end
         default: begin
            kind_in = kind_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hct_pkg::ST_IDLE;
         th_ff        <= hct_pkg::RST_TARGET_HIGH;
         tl_ff        <= hct_pkg::RST_TARGET_LOW;
         speed_ff     <= hct_pkg::RST_SPEED;
         period_ff    <= hct_pkg::RST_TICK_PERIOD;
         mode_ff      <= hct_pkg::RST_MODE;
         active_ff    <= 1'b0;
         seg_ff       <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         seg_ff       <= seg_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               hct_pkg::CSR_TARGET_HIGH: th_ff     <= csr_wdata;
               hct_pkg::CSR_TARGET_LOW:  tl_ff     <= csr_wdata;
               hct_pkg::CSR_SPEED:       speed_ff  <= csr_wdata[23:0];
               hct_pkg::CSR_TICK_PERIOD: period_ff <= csr_wdata[7:0];
               hct_pkg::CSR_MODE:        mode_ff   <= csr_wdata[0];
               default:                  mode_ff   <= mode_ff;
            endcase
         end
      end
      sas_ff       <= sas_in;
      start_ff     <= start_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      dzero_ff     <= dzero_in;
      dur_ff       <= dur_in;
      elapsed_ff   <= elapsed_in;
      kind_ff      <= kind_in;
      meas_ff      <= meas_in;
      sw_ff        <= sw_in;
      prod_ff      <= prod_in;
      s_ff         <= s_in;
      s2_ff        <= s2_in;
      k_ff         <= k_in;
      pm_ff        <= pm_in;
      y_ff         <= y_in;
      res_pos_ff   <= res_pos_in;
      res_vel_ff   <= res_vel_in;
      res_homed_ff <= res_homed_in;
      res_busy_ff  <= res_busy_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_homed_ff <= rsp_homed_in;
      rsp_busy_ff  <= rsp_busy_in;
   end

   assign req_ready        = (state_ff == hct_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cmd_position = rsp_pos_ff;
   assign rsp_cmd_velocity = rsp_vel_ff;
   assign rsp_homed        = rsp_homed_ff;
   assign rsp_busy_res     = rsp_busy_ff;

endmodule

// File: rtl/hct_checker.sv
// ----------------------------------------------------------------------------
// Homing cubic trajectory checker
// Port-level checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`include "homing_cubic_trajectory_core_assert.svh"

module hct_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_cmd_position,
   input logic signed [31:0] rsp_cmd_velocity,
   input logic               rsp_homed,
   input logic               rsp_busy_res
);

   `HCT_ASSERT_ALWAYS(a_reset_drop, reset |=> !rsp_valid)
   `HCT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
   `HCT_ASSERT(a_one_request, req_valid && req_ready |=> !req_ready)
   `HCT_ASSERT(a_homed_zero, rsp_valid && rsp_homed |->
      !rsp_busy_res && rsp_cmd_position == 0 && rsp_cmd_velocity == 0)
   `HCT_ASSERT(a_idle_still, rsp_valid && !rsp_busy_res |-> rsp_cmd_velocity == 0)

endmodule

bind homing_cubic_trajectory_core hct_checker u_hct_checker (.*);
